// ===== design/modular_exponentiation_macros.svh =====
// Assertion macros shared by the modular exponentiation checker.
// No dependencies; included by files that assert.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// same-cycle implication, off during reset
`define ME_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("me assertion failed");

// next-cycle implication, off during reset
`define ME_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("me assertion failed");

// state in the cycle after reset
`define ME_ASSERT_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("me assertion failed");

`endif

// ===== design/me_pkg.sv =====
// Shared constants and types for the modular exponentiation block.
// No dependencies.
package me_pkg;

   localparam int FIELD_W = 64;

   typedef struct packed {
      logic start;
      logic reduce;
   } mm_ctrl_type;

endpackage

// ===== design/me_if.sv =====
// Request and response channel interfaces (valid/ready).
// Depends on me_pkg.
interface me_req_if;
   logic                        valid;
   logic                        ready;
   logic [me_pkg::FIELD_W-1:0]  base;
   logic [me_pkg::FIELD_W-1:0]  exponent;
   logic [me_pkg::FIELD_W-1:0]  modulus;

   modport source (output valid, base, exponent, modulus, input ready);
   modport sink (input valid, base, exponent, modulus, output ready);
endinterface

interface me_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [me_pkg::FIELD_W-1:0]  power_result;
   logic                        zero_modulus;

   modport source (output valid, power_result, zero_modulus, input ready);
   modport sink (input valid, power_result, zero_modulus, output ready);
endinterface

// ===== design/me_mulmod.sv =====
// Bit-serial modular multiplier (shift-and-add) with a reduce mode (y mod m, MSB first).
// Depends on me_pkg.
module me_mulmod #(
   parameter int WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  me_pkg::mm_ctrl_type   ctrl,
   input  logic [WIDTH-1:0]      x_val,
   input  logic [WIDTH-1:0]      y_val,
   input  logic [WIDTH-1:0]      m_val,
   output logic                  done,
   output logic [WIDTH-1:0]      product
);

   localparam int CW = $clog2(WIDTH);

   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] x_ff, x_in;
   logic [WIDTH-1:0] y_ff, y_in;
   logic [WIDTH-1:0] m_ff, m_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             reduce_ff, reduce_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [WIDTH:0]   dbl_src, dbl_diff, sum_raw, sum_diff;
   logic [WIDTH-1:0] dbl_mod, sum_mod;
   logic             last;

   // doubling: x in multiply mode, acc plus next bit in reduce mode
   assign dbl_src  = reduce_ff ? {acc_ff, y_ff[WIDTH-1]} : {x_ff, 1'b0};
   assign dbl_diff = dbl_src - {1'b0, m_ff};
   assign dbl_mod  = (dbl_src >= {1'b0, m_ff}) ? dbl_diff[WIDTH-1:0] : dbl_src[WIDTH-1:0];

   assign sum_raw  = {1'b0, acc_ff} + {1'b0, x_ff};
   assign sum_diff = sum_raw - {1'b0, m_ff};
   assign sum_mod  = (sum_raw >= {1'b0, m_ff}) ? sum_diff[WIDTH-1:0] : sum_raw[WIDTH-1:0];

   assign last = reduce_ff ? (cnt_ff == '0) : (y_ff[WIDTH-1:1] == '0);

   always_comb begin
      acc_in    = acc_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      m_in      = m_ff;
      cnt_in    = cnt_ff;
      reduce_in = reduce_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (busy_ff) begin
         if (reduce_ff) begin
            acc_in = dbl_mod;
            y_in   = {y_ff[WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - CW'(1);
         end else begin
            if (y_ff[0]) begin
               acc_in = sum_mod;
            end
            x_in = dbl_mod;
            y_in = {1'b0, y_ff[WIDTH-1:1]};
         end
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (ctrl.start) begin
         acc_in    = '0;
         x_in      = x_val;
         y_in      = y_val;
         m_in      = m_val;
         cnt_in    = CW'(WIDTH - 1);
         reduce_in = ctrl.reduce;
         busy_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      m_ff      <= m_in;
      cnt_ff    <= cnt_in;
      reduce_ff <= reduce_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== design/modular_exponentiation.sv =====
// channel  dir  fields                              transfer when
// req_if   in   base, exponent, modulus (64 each)   valid && ready
// rsp_if   out  power_result (64), zero_modulus     valid && ready
//
// One item at a time; the pace is set by the bit-serial multiplier, up to two products per exponent bit.
// The base is first reduced mod the modulus; a zero modulus goes straight to the result.
// Synchronous reset returns to idle with no response pending.
// The result register frees the engine; a new request is taken while a response stalls.
// Depends on me_pkg, me_if and me_mulmod.
module modular_exponentiation #(
   parameter int WIDTH = 64
) (
   input logic      clock,
   input logic      reset,
   me_req_if.sink   req_if,
   me_rsp_if.source rsp_if
);

   localparam int FW = me_pkg::FIELD_W;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_REDUCE  = 7'b0000010,
      ST_EXP     = 7'b0000100,
      ST_MUL     = 7'b0001000,
      ST_SQR_CHK = 7'b0010000,
      ST_SQR     = 7'b0100000,
      ST_DONE    = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] e_ff, e_in;
   logic [WIDTH-1:0] m_ff, m_in;
   logic [WIDTH-1:0] r_ff, r_in;
   logic             zero_ff, zero_in;
   logic             out_valid_ff, out_valid_in;
   logic [WIDTH-1:0] out_result_ff, out_result_in;
   logic             out_zero_ff, out_zero_in;

   logic [WIDTH-1:0]    req_base, req_exp, req_mod;
   logic                req_xfer, out_load;
   me_pkg::mm_ctrl_type mm_ctrl;
   logic [WIDTH-1:0]    mm_x, mm_y, mm_m, mm_product;
   logic                mm_done;

   assign req_base = req_if.base[WIDTH-1:0];
   assign req_exp  = req_if.exponent[WIDTH-1:0];
   assign req_mod  = req_if.modulus[WIDTH-1:0];

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_if.valid && req_if.ready;
   assign out_load     = (state_ff == ST_DONE) && (!out_valid_ff || rsp_if.ready);

   assign mm_x = (state_ff == ST_EXP) ? r_ff : b_ff;
   assign mm_y = (state_ff == ST_IDLE) ? req_base : b_ff;
   assign mm_m = (state_ff == ST_IDLE) ? req_mod : m_ff;

   always_comb begin
      state_in       = state_ff;
      b_in           = b_ff;
      e_in           = e_ff;
      m_in           = m_ff;
      r_in           = r_ff;
      zero_in        = zero_ff;
      mm_ctrl.start  = 1'b0;
      mm_ctrl.reduce = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               b_in    = req_base;
               e_in    = req_exp;
               m_in    = req_mod;
               zero_in = (req_mod == '0);
               r_in    = WIDTH'(req_mod > WIDTH'(1));
               if (req_mod == '0) begin
                  state_in = ST_DONE;
               end else begin
                  mm_ctrl.start  = 1'b1;
                  mm_ctrl.reduce = 1'b1;
                  state_in       = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mm_done) begin
               b_in     = mm_product;
               state_in = ST_EXP;
            end
         end
         ST_EXP: begin
            if (e_ff[0]) begin
               mm_ctrl.start = 1'b1;
               state_in      = ST_MUL;
            end else begin
               state_in = ST_SQR_CHK;
            end
         end
         ST_MUL: begin
            if (mm_done) begin
               r_in     = mm_product;
               state_in = ST_SQR_CHK;
            end
         end
         ST_SQR_CHK: begin
            e_in = {1'b0, e_ff[WIDTH-1:1]};
            if (e_ff[WIDTH-1:1] == '0) begin
               state_in = ST_DONE;
            end else begin
               mm_ctrl.start = 1'b1;
               state_in      = ST_SQR;
            end
         end
         ST_SQR: begin
            if (mm_done) begin
               b_in     = mm_product;
               state_in = ST_EXP;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_result_in = out_result_ff;
      out_zero_in   = out_zero_ff;
      if (rsp_if.valid && rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in  = 1'b1;
         out_result_in = r_ff;
         out_zero_in   = zero_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_ff          <= b_in;
      e_ff          <= e_in;
      m_ff          <= m_in;
      r_ff          <= r_in;
      zero_ff       <= zero_in;
      out_result_ff <= out_result_in;
      out_zero_ff   <= out_zero_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   me_mulmod #(
      .WIDTH (WIDTH)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mm_ctrl),
      .x_val   (mm_x),
      .y_val   (mm_y),
      .m_val   (mm_m),
      .done    (mm_done),
      .product (mm_product)
   );

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.power_result = FW'(out_result_ff);
   assign rsp_if.zero_modulus = out_zero_ff;

endmodule

// ===== design/me_checker.sv =====
// Port-level checks for modular_exponentiation, attached by bind.
// Depends on me_pkg and modular_exponentiation_macros.svh.
`include "modular_exponentiation_macros.svh"

module me_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [me_pkg::FIELD_W-1:0] rsp_power_result,
   input logic                       rsp_zero_modulus
);

   `ME_ASSERT_RESET(a_reset_idle, clock, reset, !rsp_valid && req_ready)
   `ME_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `ME_ASSERT_IMPL(a_zero_mod_result, clock, reset, rsp_valid && rsp_zero_modulus, rsp_power_result == '0)
   `ME_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_power_result) && $stable(rsp_zero_modulus))

endmodule

bind modular_exponentiation me_checker u_me_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_power_result (rsp_if.power_result),
   .rsp_zero_modulus (rsp_if.zero_modulus)
);

// ===== sim/tb.sv =====
// Testbench for modular_exponentiation: drives base/exponent/modulus transfers and checks
// each response against a built-in square-and-multiply predictor under varied idling.
// Depends on me_pkg, me_if and the modular_exponentiation RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W              = me_pkg::FIELD_W;
   localparam int WATCHDOG_LIMIT = 50000;
   localparam int DRAIN_CYCLES   = 20;

   typedef logic [W-1:0] word_type;

   typedef struct packed {
      word_type power_result;
      logic     zero_modulus;
   } power_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   me_req_if req_ch ();
   me_rsp_if rsp_ch ();

   modular_exponentiation #(.WIDTH(W)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #2 clock = ~clock;

   power_rsp_type power_q[$];
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int fail_count    = 0;
   int sent_count    = 0;
   int checked_count = 0;
   int zero_mod_count = 0;
   int long_exp_count = 0;
   int stall_cycles  = 0;

   function automatic word_type mul_mod(word_type x, word_type y, word_type m);
      logic [2*W-1:0] prod;
      prod = {{W{1'b0}}, x} * {{W{1'b0}}, y};
      return word_type'(prod % {{W{1'b0}}, m});
   endfunction

   function automatic power_rsp_type predict_power(word_type b, word_type e, word_type m);
      power_rsp_type res;
      word_type sq;
      word_type acc;
      if (m == '0) begin
         res.power_result = '0;
         res.zero_modulus = 1'b1;
         return res;
      end
      sq  = b % m;
      acc = word_type'(1) % m;
      for (int i = 0; i < W; i++) begin
         if (e[0]) acc = mul_mod(acc, sq, m);
         e  = e >> 1;
         sq = mul_mod(sq, sq, m);
      end
      res.power_result = acc;
      res.zero_modulus = 1'b0;
      return res;
   endfunction

   function automatic word_type rand64();
      return {$urandom(), $urandom()};
   endfunction

   // random value of exactly n significant bits
   function automatic word_type rand_bits(int n);
      word_type v;
      v = rand64() >> (W - n);
      v[n-1] = 1'b1;
      return v;
   endfunction

   // prediction on request transfer, comparison on response transfer
   always @(posedge clock) begin
      power_rsp_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            power_q.push_back(predict_power(req_ch.base, req_ch.exponent, req_ch.modulus));
            if (req_ch.modulus == '0) zero_mod_count++;
            if (req_ch.exponent[W-1]) long_exp_count++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (power_q.size() == 0) begin
               $error("response with no request outstanding: power_result %h zero_modulus %b",
                      rsp_ch.power_result, rsp_ch.zero_modulus);
               fail_count++;
            end else begin
               want = power_q.pop_front();
               checked_count++;
               if (rsp_ch.power_result !== want.power_result) begin
                  $error("power_result: expected %h, got %h",
                         want.power_result, rsp_ch.power_result);
                  fail_count++;
               end
               if (rsp_ch.zero_modulus !== want.zero_modulus) begin
                  $error("zero_modulus: expected %b, got %b",
                         want.zero_modulus, rsp_ch.zero_modulus);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_power(word_type b, word_type e, word_type m);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid    <= 1'b1;
      req_ch.base     <= b;
      req_ch.exponent <= e;
      req_ch.modulus  <= m;
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
   endtask

   // hold off new requests until all responses are back
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (power_q.size() != 0);
   endtask

   task automatic test_zero_modulus();
      send_power(64'd5, 64'd3, '0);
      send_power('1, '1, '0);
      send_power('0, '0, '0);
   endtask

   task automatic test_trivial_cases();
      send_power(64'd7, '0, 64'd13);
      send_power('0, '0, 64'd1);
      send_power('1, '0, '1);
      send_power(64'd123456, 64'hffff, 64'd1);
      send_power('0, '0, 64'd97);
      send_power('0, 64'd9, 64'd97);
      send_power(64'd1, rand64(), rand64());
      send_power(64'd1000, 64'd3, 64'd7);
      send_power(rand64(), 64'd1, 64'd2);
   endtask

   task automatic test_extreme_operands();
      send_power('1, '1, '1);
      send_power('1, '1, 64'h8000_0000_0000_0001);
      send_power(64'd2, 64'hffff_ffff_ffff_ffc4, 64'hffff_ffff_ffff_ffc5);
      send_power(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, '1);
      send_power(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 64'h8000_0000_0000_0001);
      send_power(rand64(), 64'd1, 64'h8000_0000_0000_0000);
      send_power(rand64(), 64'd2, 64'h7fff_ffff_ffff_ffff);
      send_power(64'h8000_0000_0000_0000, 64'd5, '1);
   endtask

   task automatic test_random(int count);
      word_type b;
      word_type e;
      word_type m;
      int pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 5)       m = '0;
         else if (pick < 10) m = 64'd1;
         else if (pick < 35) m = rand_bits($urandom_range(2, 16));
         else if (pick < 60) m = rand_bits(W);
         else                m = rand64();
         pick = $urandom_range(99);
         if (pick < 5)       e = '0;
         else if (pick < 15) e = rand64();
         else                e = rand_bits($urandom_range(1, 20));
         pick = $urandom_range(99);
         if (pick < 10)                  b = '0;
         else if (pick < 25 && m != '0)  b = rand64() % m;
         else                            b = rand64();
         send_power(b, e, m);
      end
   endtask

   initial begin
      req_ch.valid    <= 1'b0;
      req_ch.base     <= '0;
      req_ch.exponent <= '0;
      req_ch.modulus  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 21;
      rsp_idle_pct  = 47;
      test_zero_modulus();
      test_trivial_cases();
      drain();
      test_extreme_operands();
      drain();
      test_random(27);
      drain();

      send_idle_pct = 47;
      rsp_idle_pct  = 21;
      test_random(27);
      drain();

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_random(26);
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (power_q.size() != 0) begin
         $error("%0d responses never arrived", power_q.size());
         fail_count++;
      end
      $display("Ran %0d exponentiations, %0d responses checked: %0d zero-modulus, %0d with bit 63",
               sent_count, checked_count, zero_mod_count, long_exp_count);
      $display("of the exponent set, across sender-heavy, receiver-heavy and no-idle mixes");
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== modular_exponentiation.f =====
+incdir+design
design/me_pkg.sv
design/me_if.sv
design/me_mulmod.sv
design/modular_exponentiation.sv
design/me_checker.sv
sim/tb.sv
